// ===== rtl/core/tbw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbw_pkg: shared types, constants and arithmetic for the blend weight block
// Fixed-point formats, source count codes, weight mode decode, saturation,
// folding and the rounded multiply that every weight product uses.
// ----------------------------------------------------------------------------
package tbw_pkg;

  // Fixed-point format of coordinates and weights.
  localparam int FRAC_BITS = 15;
  localparam int COORD_W   = 16;
  localparam int WEIGHT_W  = 16;
  localparam int CNT_W     = 4;
  localparam int FACT_W    = FRAC_BITS + 1;
  localparam int CMP_W     = (FACT_W > COORD_W) ? FACT_W : COORD_W;
  localparam int PROD_W    = 2 * FACT_W;

  typedef logic [FACT_W-1:0] fact_t;

  localparam fact_t FIX_ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [PROD_W-1:0] PROD_HALF = (PROD_W)'(1) << (FRAC_BITS - 1);

  // Source count codes accepted by the configuration register.
  localparam logic [CNT_W-1:0] CNT_LIN1  = 4'd1;
  localparam logic [CNT_W-1:0] CNT_LIN2  = 4'd2;
  localparam logic [CNT_W-1:0] CNT_LIN3  = 4'd3;
  localparam logic [CNT_W-1:0] CNT_BIL4  = 4'd4;
  localparam logic [CNT_W-1:0] CNT_FOLD6 = 4'd6;
  localparam logic [CNT_W-1:0] CNT_TRI8  = 4'd8;
  localparam logic [CNT_W-1:0] CNT_FOLD9 = 4'd9;
  localparam logic [CNT_W-1:0] CNT_TRI12 = 4'd12;

  // Weight modes after decoding the source count.
  typedef enum logic [2:0] {
    MODE_LIN,
    MODE_BIL,
    MODE_BIL_FX,
    MODE_BIL_FXY,
    MODE_TRI,
    MODE_TRI_FX,
    MODE_ERR
  } mode_t;

  // Corner order of the folded trilinear mode. Each entry selects
  // {z factor is z, y factor is y, x factor is x}.
  localparam logic [2:0] TRI12_SEL [8] = '{
    3'b000, 3'b010, 3'b110, 3'b100, 3'b001, 3'b011, 3'b111, 3'b101
  };

  // Input transaction payload.
  typedef struct packed {
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic [COORD_W-1:0] coord_z;
  } in_item_t;

  // Result transaction payload.
  typedef struct packed {
    logic [WEIGHT_W-1:0] weight0;
    logic [WEIGHT_W-1:0] weight1;
    logic [WEIGHT_W-1:0] weight2;
    logic [WEIGHT_W-1:0] weight3;
    logic [WEIGHT_W-1:0] weight4;
    logic [WEIGHT_W-1:0] weight5;
    logic [WEIGHT_W-1:0] weight6;
    logic [WEIGHT_W-1:0] weight7;
    logic                x_fold_negative;
    logic                y_fold_negative;
    logic                mode_error;
  } out_item_t;

  // Result of folding one coordinate about one half.
  typedef struct packed {
    fact_t val;
    logic  neg;
  } fold_t;

  function automatic mode_t decode_mode(input logic [CNT_W-1:0] cnt);
    mode_t m;
    case (cnt)
      CNT_LIN1, CNT_LIN2, CNT_LIN3: m = MODE_LIN;
      CNT_BIL4:  m = MODE_BIL;
      CNT_FOLD6: m = MODE_BIL_FX;
      CNT_FOLD9: m = MODE_BIL_FXY;
      CNT_TRI8:  m = MODE_TRI;
      CNT_TRI12: m = MODE_TRI_FX;
      default:   m = MODE_ERR;
    endcase
    return m;
  endfunction

  // Saturate a coordinate to 1.0.
  function automatic fact_t clamp_one(input logic [COORD_W-1:0] c);
    logic [CMP_W-1:0] e;
    e = (CMP_W)'(c);
    return (e > (CMP_W)'(FIX_ONE)) ? FIX_ONE : (FACT_W)'(e);
  endfunction

  // Map t to |2t - 1|; the sign is negative when t lies below one half.
  function automatic fold_t fold(input fact_t t);
    logic [FACT_W:0] d;
    logic [FACT_W:0] one_e;
    fold_t r;
    d     = {t, 1'b0};
    one_e = (FACT_W + 1)'(FIX_ONE);
    if (d >= one_e) begin
      r.val = (FACT_W)'(d - one_e);
      r.neg = 1'b0;
    end else begin
      r.val = (FACT_W)'(one_e - d);
      r.neg = 1'b1;
    end
    return r;
  endfunction

  // Product of two factors, rounded to nearest with ties going up.
  function automatic fact_t mul_round(input fact_t a, input fact_t b);
    logic [PROD_W-1:0] p;
    p = (PROD_W)'(a) * (PROD_W)'(b) + PROD_HALF;
    return (FACT_W)'(p >> FRAC_BITS);
  endfunction

endpackage

// ===== rtl/core/tbw_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbw_if: valid/ready channels of the blend weight block
// Coordinate input channel, weight result channel and the configuration
// write channel, each with a source and a sink side.
// ----------------------------------------------------------------------------

// Coordinate triple channel.
interface tbw_in_if import tbw_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Blend weight result channel.
interface tbw_out_if import tbw_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Source count write channel.
interface tbw_cfg_if import tbw_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/trilinear_blend_weights.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trilinear_blend_weights: pipelined linear, bilinear and trilinear weights
// Turns one coordinate triple per transaction into up to eight Q1.15 blend
// weights, with optional folding of x and y, in the mode set by source_count.
// ----------------------------------------------------------------------------
// The block accepts one coordinate transaction per clock while the output
// side is not stalled. Each result passes three register stages: saturate
// and fold, the x-by-y products, and the z products with the final weight
// selection, which feeds the output register. A stall on the result channel
// holds every stage that is full; empty stages still fill, so no bubble is
// kept. There is no clearing pass after reset. Write source_count only while
// the pipeline is empty; the register is always ready.

module trilinear_blend_weights
  import tbw_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  tbw_in_if.sink    in_chan,
  tbw_out_if.source out_chan,
  tbw_cfg_if.sink   cfg_chan
);

  // Configuration register.
  logic [CNT_W-1:0] src_count_r;

  // Stage 1: saturated and folded factors.
  logic  s1_v_r;
  mode_t s1_mode_r;
  fact_t s1_x_r, s1_nx_r, s1_y_r, s1_ny_r, s1_z_r, s1_nz_r;
  logic  s1_xneg_r, s1_yneg_r;

  // Stage 2: rounded x-by-y products, indexed by {y is y, x is x}.
  logic  s2_v_r;
  mode_t s2_mode_r;
  fact_t s2_p_r [4];
  fact_t s2_x_r, s2_nx_r, s2_z_r, s2_nz_r;
  logic  s2_xneg_r, s2_yneg_r;

  // Stage 3: output register.
  logic      out_v_r;
  out_item_t out_r;

  // Stage enables.
  logic en1, en2, en3;

  // Stage 1 combinational signals.
  mode_t mode_nxt;
  fact_t cx, cy, cz, x_nxt, y_nxt;
  fold_t fx, fy;
  logic  xneg_nxt, yneg_nxt;

  // Stage 2 and stage 3 combinational signals.
  fact_t     p_nxt [4];
  fact_t     t_prod [8];
  fact_t     w [8];
  out_item_t out_nxt;

  // A stage loads when it is empty or when the stage after it moves.
  assign en3 = !out_v_r || out_chan.ready;
  assign en2 = !s2_v_r || en3;
  assign en1 = !s1_v_r || en2;

  assign in_chan.ready  = en1;
  assign cfg_chan.ready = 1'b1;
  assign out_chan.valid = out_v_r;
  assign out_chan.data  = out_r;

  // Source count register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_count_r <= CNT_TRI8;
    end else if (cfg_chan.valid) begin
      src_count_r <= cfg_chan.data;
    end
  end

  // Saturate the coordinates and fold where the mode asks for it.
  always_comb begin
    mode_nxt = decode_mode(src_count_r);
    cx = clamp_one(in_chan.data.coord_x);
    cy = clamp_one(in_chan.data.coord_y);
    cz = clamp_one(in_chan.data.coord_z);
    fx = fold(cx);
    fy = fold(cy);
    x_nxt = cx;
    y_nxt = cy;
    xneg_nxt = 1'b0;
    yneg_nxt = 1'b0;
    if (mode_nxt == MODE_BIL_FX || mode_nxt == MODE_BIL_FXY ||
        mode_nxt == MODE_TRI_FX) begin
      x_nxt    = fx.val;
      xneg_nxt = fx.neg;
    end
    if (mode_nxt == MODE_BIL_FXY) begin
      y_nxt    = fy.val;
      yneg_nxt = fy.neg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en1) begin
      s1_v_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_mode_r <= mode_nxt;
      s1_x_r    <= x_nxt;
      s1_nx_r   <= FIX_ONE - x_nxt;
      s1_y_r    <= y_nxt;
      s1_ny_r   <= FIX_ONE - y_nxt;
      s1_z_r    <= cz;
      s1_nz_r   <= FIX_ONE - cz;
      s1_xneg_r <= xneg_nxt;
      s1_yneg_r <= yneg_nxt;
    end
  end

  // The four x-by-y products.
  always_comb begin
    p_nxt[0] = mul_round(s1_nx_r, s1_ny_r);
    p_nxt[1] = mul_round(s1_x_r,  s1_ny_r);
    p_nxt[2] = mul_round(s1_nx_r, s1_y_r);
    p_nxt[3] = mul_round(s1_x_r,  s1_y_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en2) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_mode_r <= s1_mode_r;
      s2_p_r    <= p_nxt;
      s2_x_r    <= s1_x_r;
      s2_nx_r   <= s1_nx_r;
      s2_z_r    <= s1_z_r;
      s2_nz_r   <= s1_nz_r;
      s2_xneg_r <= s1_xneg_r;
      s2_yneg_r <= s1_yneg_r;
    end
  end

  // Products with the z factor, indexed by {z is z, y is y, x is x}.
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      t_prod[j] = mul_round(s2_p_r[j % 4], (j >= 4) ? s2_z_r : s2_nz_r);
    end
  end

  // Pick the weights of the mode; unused weights stay zero.
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      w[k] = '0;
    end
    out_nxt = '0;
    case (s2_mode_r)
      MODE_LIN: begin
        w[0] = s2_nx_r;
        w[1] = s2_x_r;
      end
      MODE_BIL, MODE_BIL_FX, MODE_BIL_FXY: begin
        w[0] = s2_p_r[0];
        w[1] = s2_p_r[1];
        w[2] = s2_p_r[3];
        w[3] = s2_p_r[2];
      end
      MODE_TRI: begin
        for (int k = 0; k < 8; k++) begin
          w[k] = t_prod[k];
        end
      end
      MODE_TRI_FX: begin
        for (int k = 0; k < 8; k++) begin
          w[k] = t_prod[TRI12_SEL[k]];
        end
      end
      default: begin
        out_nxt.mode_error = 1'b1;
      end
    endcase
    out_nxt.weight0 = (WEIGHT_W)'(w[0]);
    out_nxt.weight1 = (WEIGHT_W)'(w[1]);
    out_nxt.weight2 = (WEIGHT_W)'(w[2]);
    out_nxt.weight3 = (WEIGHT_W)'(w[3]);
    out_nxt.weight4 = (WEIGHT_W)'(w[4]);
    out_nxt.weight5 = (WEIGHT_W)'(w[5]);
    out_nxt.weight6 = (WEIGHT_W)'(w[6]);
    out_nxt.weight7 = (WEIGHT_W)'(w[7]);
    out_nxt.x_fold_negative = s2_xneg_r;
    out_nxt.y_fold_negative = s2_yneg_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en3) begin
      out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      out_r <= out_nxt;
    end
  end

  // An unsupported count yields an all-zero result apart from the error flag.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.data.mode_error |->
      out_chan.data.weight0 == '0 && out_chan.data.weight1 == '0 &&
      out_chan.data.weight2 == '0 && out_chan.data.weight3 == '0 &&
      out_chan.data.weight4 == '0 && out_chan.data.weight5 == '0 &&
      out_chan.data.weight6 == '0 && out_chan.data.weight7 == '0 &&
      !out_chan.data.x_fold_negative && !out_chan.data.y_fold_negative)
    else $error("mode error result carries nonzero fields");

  // Folding y only happens together with folding x.
  a_yfold_mode: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r && s2_yneg_r |-> s2_mode_r == MODE_BIL_FXY)
    else $error("y fold flag outside the double fold mode");

  // A stalled output keeps the transaction waiting behind it.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_chan.ready && s2_v_r |=> s2_v_r && $stable(s2_p_r[0]))
    else $error("stage two lost its transaction during a stall");

  // Input is refused only when all three stages are full.
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> s1_v_r && s2_v_r && out_v_r)
    else $error("input refused with an empty stage");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for trilinear_blend_weights
// Drives coordinate triples through the valid/ready input channel, computes
// the expected blend weights in a local predictor and checks every result
// transaction field by field, over all source count settings.
// ----------------------------------------------------------------------------

module testbench;
  import tbw_pkg::*;

  // 1.0 in the fixed-point format of coordinates and weights.
  localparam int unsigned UNIT = 1 << FRAC_BITS;
  localparam int HOLD_CYCLES   = 200;
  localparam int IDLE_LIMIT    = 3000;
  localparam int DRAIN_CYCLES  = 8;

  localparam logic [CNT_W-1:0] VALID_COUNTS [8] = '{
    CNT_LIN1, CNT_LIN2, CNT_LIN3, CNT_BIL4, CNT_FOLD6, CNT_TRI8, CNT_FOLD9, CNT_TRI12
  };
  localparam logic [CNT_W-1:0] UNSUPPORTED_COUNTS [8] = '{
    4'd0, 4'd5, 4'd7, 4'd10, 4'd11, 4'd13, 4'd14, 4'd15
  };

  logic clk = 1'b0;
  logic rst_n;

  tbw_in_if  in_chan ();
  tbw_out_if out_chan ();
  tbw_cfg_if cfg_chan ();

  trilinear_blend_weights i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  out_item_t        expected_weights [$];
  logic [CNT_W-1:0] active_count;
  int               error_count = 0;
  int               quiet_cycles = 0;
  bit               idle_enable;
  bit               hold_request;

  // Clock generation.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic int unsigned sat_coord(input logic [COORD_W-1:0] c);
    return (c > UNIT) ? UNIT : int'(c);
  endfunction

  // Rounded fixed-point product, ties go up.
  function automatic int unsigned round_mul(input int unsigned a, input int unsigned b);
    longint unsigned p;
    p = a;
    p = p * b + (UNIT / 2);
    return int'(p >> FRAC_BITS);
  endfunction

  // Map t to |2t - 1| and flag when t lies below one half.
  function automatic int unsigned fold_about_half(input int unsigned t, output logic neg);
    int unsigned d;
    d = 2 * t;
    neg = (d < UNIT);
    return neg ? (UNIT - d) : (d - UNIT);
  endfunction

  function automatic out_item_t blend_weights_for(input in_item_t c,
                                                  input logic [CNT_W-1:0] cnt);
    int unsigned x, y, z, nx, ny, nz, fx, fy;
    int unsigned w [8];
    logic        xneg, yneg, err;
    bit          xs, ys, zs;
    out_item_t   r;
    x = sat_coord(c.coord_x);
    y = sat_coord(c.coord_y);
    z = sat_coord(c.coord_z);
    xneg = 1'b0;
    yneg = 1'b0;
    err  = 1'b0;
    for (int k = 0; k < 8; k++) w[k] = 0;
    case (cnt)
      CNT_LIN1, CNT_LIN2, CNT_LIN3: begin
        w[0] = UNIT - x;
        w[1] = x;
      end
      CNT_BIL4, CNT_FOLD6, CNT_FOLD9: begin
        if (cnt != CNT_BIL4) x = fold_about_half(x, xneg);
        if (cnt == CNT_FOLD9) y = fold_about_half(y, yneg);
        nx = UNIT - x;
        ny = UNIT - y;
        w[0] = round_mul(nx, ny);
        w[1] = round_mul(x, ny);
        w[2] = round_mul(x, y);
        w[3] = round_mul(nx, y);
      end
      CNT_TRI8, CNT_TRI12: begin
        if (cnt == CNT_TRI12) x = fold_about_half(x, xneg);
        nx = UNIT - x;
        ny = UNIT - y;
        nz = UNIT - z;
        for (int k = 0; k < 8; k++) begin
          if (cnt == CNT_TRI8) begin
            // Bits of the index pick x, y and z directly.
            xs = k[0];
            ys = k[1];
            zs = k[2];
          end else begin
            // The folded order walks the y-z square for each x half.
            xs = k[2];
            ys = k[0] ^ k[1];
            zs = k[1];
          end
          fx = xs ? x : nx;
          fy = ys ? y : ny;
          w[k] = round_mul(round_mul(fx, fy), zs ? z : nz);
        end
      end
      default: begin
        err = 1'b1;
      end
    endcase
    r.weight0 = 16'(w[0]);
    r.weight1 = 16'(w[1]);
    r.weight2 = 16'(w[2]);
    r.weight3 = 16'(w[3]);
    r.weight4 = 16'(w[4]);
    r.weight5 = 16'(w[5]);
    r.weight6 = 16'(w[6]);
    r.weight7 = 16'(w[7]);
    r.x_fold_negative = xneg;
    r.y_fold_negative = yneg;
    r.mode_error      = err;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitors: register shadow, expected results and the watchdog
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst_n) begin
      active_count = CNT_TRI8;
    end else begin
      if (cfg_chan.valid && cfg_chan.ready) active_count = cfg_chan.data;
      if (in_chan.valid && in_chan.ready)
        expected_weights.push_back(blend_weights_for(in_chan.data, active_count));
    end
    // Count cycles in which no transaction moves on any channel.
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
        (cfg_chan.valid && cfg_chan.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("trilinear_blend_weights: mismatch");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [15:0] expv,
                             input logic [15:0] actv);
    if (actv !== expv) begin
      $error("%s: expected %0d, got %0d", name, expv, actv);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : result_checker
    out_item_t want, got;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got = out_chan.data;
      if (expected_weights.size() == 0) begin
        $error("result transaction with no expected result waiting");
        error_count++;
      end else begin
        want = expected_weights.pop_front();
        check_field("weight0", want.weight0, got.weight0);
        check_field("weight1", want.weight1, got.weight1);
        check_field("weight2", want.weight2, got.weight2);
        check_field("weight3", want.weight3, got.weight3);
        check_field("weight4", want.weight4, got.weight4);
        check_field("weight5", want.weight5, got.weight5);
        check_field("weight6", want.weight6, got.weight6);
        check_field("weight7", want.weight7, got.weight7);
        check_field("x_fold_negative", 16'(want.x_fold_negative), 16'(got.x_fold_negative));
        check_field("y_fold_negative", 16'(want.y_fold_negative), 16'(got.y_fold_negative));
        check_field("mode_error", 16'(want.mode_error), 16'(got.mode_error));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result ready driver: random stall bursts and the long hold-off
  // ---------------------------------------------------------------------------

  initial begin : result_ready_driver
    int n;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_request = 1'b0;
      end else if (idle_enable && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 10);
        out_chan.ready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic in_item_t make_coords(input logic [COORD_W-1:0] x,
                                           input logic [COORD_W-1:0] y,
                                           input logic [COORD_W-1:0] z);
    in_item_t c;
    c.coord_x = x;
    c.coord_y = y;
    c.coord_z = z;
    return c;
  endfunction

  // Mix of edge values, in-range values and raw 16-bit values.
  function automatic logic [COORD_W-1:0] coord_sample();
    case ($urandom_range(0, 9))
      0, 1: begin
        case ($urandom_range(0, 7))
          0: return 16'd0;
          1: return 16'd1;
          2: return 16'd16383;
          3: return 16'd16384;
          4: return 16'd16385;
          5: return 16'd32767;
          6: return 16'd32768;
          default: return 16'hFFFF;
        endcase
      end
      2, 3: return 16'($urandom);
      default: return 16'($urandom_range(0, UNIT));
    endcase
  endfunction

  // Send one coordinate transaction; called and returns at a falling edge.
  task automatic send_coords(input in_item_t c);
    int n;
    in_chan.valid <= 1'b1;
    in_chan.data  <= c;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 10);
      in_chan.valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++)
      send_coords(make_coords(coord_sample(), coord_sample(), coord_sample()));
  endtask

  // Stop offering items and wait until every expected result has arrived.
  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    @(negedge clk);
    while (expected_weights.size() != 0) @(negedge clk);
  endtask

  // Write source_count once the pipeline is empty.
  task automatic write_source_count(input logic [CNT_W-1:0] cnt);
    wait_drained();
    cfg_chan.valid <= 1'b1;
    cfg_chan.data  <= cnt;
    do @(posedge clk); while (!cfg_chan.ready);
    @(negedge clk);
    cfg_chan.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset mode, each mode with its edge values, folds at one half,
  // saturation above one and every unsupported count.
  task automatic test_directed_modes();
    send_coords(make_coords(16'd0, 16'd0, 16'd0));
    send_coords(make_coords(16'd32768, 16'd32768, 16'd32768));
    send_coords(make_coords(16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_coords(make_coords(16'd1, 16'd32767, 16'd16384));
    write_source_count(CNT_TRI12);
    send_coords(make_coords(16'd16384, 16'd16383, 16'd16385));
    send_coords(make_coords(16'd0, 16'd32768, 16'd1));
    write_source_count(CNT_FOLD9);
    send_coords(make_coords(16'd16384, 16'd16384, 16'd0));
    send_coords(make_coords(16'd16383, 16'd16385, 16'hFFFF));
    write_source_count(CNT_FOLD6);
    send_coords(make_coords(16'd32767, 16'd1, 16'hFFFF));
    write_source_count(CNT_BIL4);
    send_coords(make_coords(16'd12345, 16'hD431, 16'd0));
    write_source_count(CNT_LIN1);
    send_coords(make_coords(16'd0, 16'hFFFF, 16'hFFFF));
    write_source_count(CNT_LIN2);
    send_coords(make_coords(16'd32768, 16'd0, 16'd0));
    write_source_count(CNT_LIN3);
    send_coords(make_coords(16'd40000, 16'd5, 16'd7));
    foreach (UNSUPPORTED_COUNTS[i]) begin
      write_source_count(UNSUPPORTED_COUNTS[i]);
      send_coords(make_coords(coord_sample(), coord_sample(), coord_sample()));
    end
  endtask

  // Random phases, each under its own source count and idling choice.
  task automatic test_random_phases();
    logic [CNT_W-1:0] cnt;
    for (int p = 0; p < 16; p++) begin
      if (p < 8) cnt = VALID_COUNTS[p];
      else if ($urandom_range(0, 4) == 0) cnt = CNT_W'($urandom_range(0, 15));
      else cnt = VALID_COUNTS[$urandom_range(0, 7)];
      write_source_count(cnt);
      idle_enable = ($urandom_range(0, 3) != 0);
      send_random($urandom_range(40, 70));
    end
    idle_enable = 1'b1;
  endtask

  // Hold the result channel off while items keep coming, so the pipeline
  // fills and stalls its input.
  task automatic test_full_pipeline_stall();
    write_source_count(CNT_TRI12);
    hold_request = 1'b1;
    send_random(60);
    while (hold_request) @(negedge clk);
  endtask

  // Sender pauses mid-stream until every result is back.
  task automatic test_drain_pause();
    write_source_count(CNT_FOLD9);
    send_random(40);
    wait_drained();
    send_random(40);
  endtask

  // Back-to-back traffic with no idling on either side.
  task automatic test_streaming_no_idle();
    write_source_count(CNT_TRI8);
    idle_enable = 1'b0;
    send_random(150);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n          = 1'b0;
    in_chan.valid  = 1'b0;
    in_chan.data   = '0;
    cfg_chan.valid = 1'b0;
    cfg_chan.data  = '0;
    idle_enable    = 1'b1;
    hold_request   = 1'b0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    test_directed_modes();
    test_random_phases();
    test_full_pipeline_stall();
    test_drain_pause();
    test_streaming_no_idle();

    // Let the pipeline empty, then report.
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_weights.size() == 0) begin
      $display("trilinear_blend_weights: match");
    end else begin
      $display("trilinear_blend_weights: mismatch");
    end
    $finish;
  end

endmodule
